/* design/nrs_pkg.sv */
// shared types and constants for the top-n rank sorter
// used by the controller, the datapath and the top level; no dependencies
package nrs_pkg;

    // storage geometry
    localparam int MAX_RECORDS = 64;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = IDX_W + 1;

    // field widths
    localparam int SCORE_W     = 32;
    localparam int TOP_W       = 7;
    localparam int RANK_W      = 6;
    localparam int OUT_DATA_W  = 8;

    // register map
    localparam int REG_TOP_COUNT = 0;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam logic [TOP_W-1:0] TOP_COUNT_RST = TOP_W'(1);

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_I,
        ST_GET_I,
        ST_CMP,
        ST_STORE,
        ST_EMIT_RD,
        ST_EMIT_PUSH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_beat;
        logic start_rank;
        logic rd_i;
        logic get_i;
        logic cmp_step;
        logic store_slot;
        logic emit_rd;
        logic emit_push;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic rank_last;
        logic cmp_done;
        logic emit_none;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

/* design/nrs_ctrl.sv */
// controller state machine of the top-n rank sorter
// depends on nrs_pkg for the state type and the command and status structs
module nrs_ctrl import nrs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_last,
    input  t_sts   i_sts,
    output logic   o_in_ready,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_last) n_state = ST_RD_I;
            end
            ST_RD_I:  n_state = ST_GET_I;
            ST_GET_I: n_state = ST_CMP;
            ST_CMP: begin
                if (i_sts.cmp_done) n_state = ST_STORE;
            end
            ST_STORE: begin
                if (!i_sts.rank_last)     n_state = ST_RD_I;
                else if (i_sts.emit_none) n_state = ST_IDLE;
                else                      n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: n_state = ST_EMIT_PUSH;
            ST_EMIT_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load_beat  = i_in_valid;
                o_cmd.start_rank = i_in_valid && i_in_last;
            end
            ST_RD_I:      o_cmd.rd_i       = 1'b1;
            ST_GET_I:     o_cmd.get_i      = 1'b1;
            ST_CMP:       o_cmd.cmp_step   = 1'b1;
            ST_STORE:     o_cmd.store_slot = 1'b1;
            ST_EMIT_RD:   o_cmd.emit_rd    = 1'b1;
            ST_EMIT_PUSH: o_cmd.emit_push  = i_sts.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/nrs_datapath.sv */
// datapath of the top-n rank sorter: score and slot memories, counters,
// compare and rank count, output register; depends on nrs_pkg
module nrs_datapath import nrs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [SCORE_W-1:0]    i_score,
    input  logic [TOP_W-1:0]      i_top_count,
    input  logic                  i_out_ready,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [RANK_W-1:0]     o_rank_index,
    output logic                  o_out_last
);

    // memories
    logic [SCORE_W-1:0] r_score_mem [MAX_RECORDS];
    logic [IDX_W-1:0]   r_slot_mem  [MAX_RECORDS];

    logic [SCORE_W-1:0] r_rd_score;
    logic [IDX_W-1:0]   r_rd_slot;

    // control counters
    logic [CNT_W-1:0]   r_loaded;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic [CNT_W-1:0]   r_cmp_j;
    logic               r_cmp_vld;
    logic [CNT_W-1:0]   r_rank;
    logic [TOP_W-1:0]   r_emit;
    logic [TOP_W-1:0]   r_k;

    // payload
    logic [SCORE_W-1:0] r_si;
    logic               r_out_valid;
    logic [RANK_W-1:0]  r_out_idx;
    logic               r_out_last;

    logic               store_ok;
    logic [CNT_W-1:0]   n_count;
    logic               cmp_issue;
    logic               beats_ahead;

    assign store_ok    = (r_loaded != CNT_W'(MAX_RECORDS));
    assign n_count     = r_loaded + CNT_W'(store_ok);
    assign cmp_issue   = i_cmd.cmp_step && (r_j != r_loaded);
    // another record beats the held one if higher, or equal and loaded earlier
    assign beats_ahead = ($signed(r_rd_score) > $signed(r_si)) ||
                         ((r_rd_score == r_si) && (r_cmp_j < r_i));

    // score memory: write while loading, one read a cycle while ranking
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_beat && store_ok) begin
            r_score_mem[r_loaded[IDX_W-1:0]] <= i_score;
        end
        if (i_cmd.rd_i) begin
            r_rd_score <= r_score_mem[r_i[IDX_W-1:0]];
        end else if (cmp_issue) begin
            r_rd_score <= r_score_mem[r_j[IDX_W-1:0]];
        end
    end

    // slot memory: written once per record, read once per result
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_slot) begin
            r_slot_mem[r_rank[IDX_W-1:0]] <= r_i[IDX_W-1:0];
        end
        if (i_cmd.emit_rd) begin
            r_rd_slot <= r_slot_mem[r_k[IDX_W-1:0]];
        end
    end

    // load count and ranking counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_cmp_j   <= '0;
            r_cmp_vld <= 1'b0;
            r_rank    <= '0;
            r_emit    <= '0;
            r_k       <= '0;
        end else begin
            if (i_cmd.load_beat && store_ok) begin
                r_loaded <= n_count;
            end
            if (i_cmd.start_rank) begin
                r_i <= '0;
                r_k <= '0;
                if (32'(i_top_count) < 32'(n_count)) begin
                    r_emit <= i_top_count;
                end else begin
                    r_emit <= TOP_W'(n_count);
                end
            end
            if (i_cmd.get_i) begin
                r_j       <= '0;
                r_rank    <= '0;
                r_cmp_vld <= 1'b0;
            end
            if (i_cmd.cmp_step) begin
                r_cmp_vld <= cmp_issue;
                if (cmp_issue) begin
                    r_j     <= r_j + CNT_W'(1);
                    r_cmp_j <= r_j;
                end
                if (r_cmp_vld && beats_ahead) begin
                    r_rank <= r_rank + CNT_W'(1);
                end
            end
            if (i_cmd.store_slot) begin
                r_i <= r_i + CNT_W'(1);
                if (o_sts.rank_last) begin
                    r_loaded <= '0;
                end
            end
            if (i_cmd.emit_push) begin
                r_k <= r_k + TOP_W'(1);
            end
        end
    end

    // held score of the record being ranked
    always_ff @(posedge i_clk) begin
        if (i_cmd.get_i) begin
            r_si <= r_rd_score;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_push) begin
            r_out_idx  <= RANK_W'(r_rd_slot);
            r_out_last <= o_sts.emit_last;
        end
    end

    // status back to the controller
    always_comb begin
        o_sts.rank_last = ((r_i + CNT_W'(1)) == r_loaded);
        o_sts.cmp_done  = (r_j == r_loaded) && !r_cmp_vld;
        o_sts.emit_none = (r_emit == '0);
        o_sts.emit_last = ((r_k + TOP_W'(1)) == r_emit);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_rank_index = r_out_idx;
    assign o_out_last   = r_out_last;

endmodule

/* design/top_n_rank_sort.sv */
// top level of the top-n rank sorter: stream ports, register port
// depends on nrs_pkg, nrs_ctrl and nrs_datapath
//
// Scores arrive one beat per cycle on the slave stream, the last of a set
// marked by tlast; up to 64 are stored and any beyond that are dropped. On
// the last beat the block ranks every stored score against all of them
// through the single score memory read port, record by record (read,
// hold, compare with every stored score, store its slot), then sends the
// load positions of the best top_count scores, best first, each read from
// the slot memory and pushed once the master side is free, tlast on the
// final one. Equal scores keep load order. Input is not taken while a set
// is ranked or sent. top_count is at register byte address 0, resets to 1.
module top_n_rank_sort import nrs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // slave stream
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [SCORE_W-1:0]      i_s_tdata,   // [31:0] score
    input  logic                    i_s_tlast,   // last_record
    // master stream
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_DATA_W-1:0]   o_m_tdata,   // [5:0] rank_index, [7:6] zero
    output logic                    o_m_tlast,   // last_result
    // register port
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic [APB_ADDR_W-1:0]   i_paddr,
    input  logic [APB_DATA_W-1:0]   i_pwdata,
    output logic [APB_DATA_W-1:0]   o_prdata,
    output logic                    o_pready
);

    t_cmd               cmd;
    t_sts               sts;
    logic [TOP_W-1:0]   r_top_count;
    logic [RANK_W-1:0]  rank_index;
    logic               reg_hit;

    // register decode
    assign reg_hit  = (i_paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_TOP_COUNT));
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= TOP_COUNT_RST;
        end else if (i_psel && i_penable && i_pwrite && reg_hit) begin
            r_top_count <= i_pwdata[TOP_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (reg_hit) begin
            o_prdata = APB_DATA_W'(r_top_count);
        end
    end

    // controller
    nrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_last  (i_s_tlast),
        .i_sts      (sts),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    // datapath
    nrs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_score      (i_s_tdata),
        .i_top_count  (r_top_count),
        .i_out_ready  (i_m_tready),
        .o_sts        (sts),
        .o_out_valid  (o_m_tvalid),
        .o_rank_index (rank_index),
        .o_out_last   (o_m_tlast)
    );

    assign o_m_tdata = OUT_DATA_W'(rank_index);

endmodule

/* tb/top_n_rank_sort_test.sv */
// self-checking testbench for top_n_rank_sort: score sets in, ranked load positions out
// depends on nrs_pkg and top_n_rank_sort; predicts each emitted beat and compares in order
`timescale 1ns / 1ps

module top_n_rank_sort_test;
    import nrs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic              last;
    } t_rank_beat;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SCORE_W-1:0]    s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [SCORE_W-1:0] held_scores[$];
    t_rank_beat         pending_ranks[$];
    logic [TOP_W-1:0]   top_count_shadow;
    int                 last_set_size;

    int mismatches;
    int cycle_count;
    int sender_idle_pct;
    int recv_stall_pct;

    top_n_rank_sort uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run length guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    // rank the held set: slot = count of strictly greater scores, ties take next free slot
    function automatic void rank_scores();
        int               n;
        int               slot;
        int               emit;
        logic [RANK_W-1:0] order[MAX_RECORDS];
        bit               taken[MAX_RECORDS];
        t_rank_beat       beat;
        n = held_scores.size();
        for (int k = 0; k < MAX_RECORDS; k++) begin
            taken[k] = 1'b0;
            order[k] = '0;
        end
        for (int i = 0; i < n; i++) begin
            slot = 0;
            for (int j = 0; j < n; j++)
                if ($signed(held_scores[i]) < $signed(held_scores[j]))
                    slot++;
            while (slot < n && taken[slot])
                slot++;
            if (slot < n) begin
                taken[slot] = 1'b1;
                order[slot] = RANK_W'(i);
            end
        end
        emit = (int'(top_count_shadow) < n) ? int'(top_count_shadow) : n;
        for (int i = 0; i < emit; i++) begin
            beat.rank = order[i];
            beat.last = (i == emit - 1);
            pending_ranks.push_back(beat);
        end
        last_set_size = n;
        held_scores.delete();
    endfunction

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // compare every accepted result beat with the oldest prediction
    always @(posedge clk) begin
        t_rank_beat want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_ranks.size() == 0) begin
                note_mismatch($sformatf("unexpected beat tdata=%h tlast=%b", m_tdata, m_tlast));
            end else begin
                want = pending_ranks.pop_front();
                if (m_tdata !== {{(OUT_DATA_W-RANK_W){1'b0}}, want.rank} ||
                        m_tlast !== want.last)
                    note_mismatch($sformatf("rank beat exp idx=%0d last=%b, got tdata=%h tlast=%b",
                                            want.rank, want.last, m_tdata, m_tlast));
            end
        end
    end

    // one score beat; tvalid stays high into the next call unless an idle cycle is drawn
    task automatic send_score(input logic [SCORE_W-1:0] score, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = score;
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        if (held_scores.size() < MAX_RECORDS)
            held_scores.push_back(score);
        if (last)
            rank_scores();
    endtask

    task automatic stop_stream();
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
    endtask

    // wait for all predicted beats, then allow a full ranking pass to finish
    task automatic wait_drained();
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (last_set_size * last_set_size + 4 * last_set_size + 40) @(posedge clk);
    endtask

    // register write followed by a read-back of top_count
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == APB_ADDR_W'(REG_TOP_COUNT * 4))
            top_count_shadow = data[TOP_W-1:0];
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = APB_ADDR_W'(REG_TOP_COUNT * 4);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DATA_W'(top_count_shadow))
            note_mismatch($sformatf("top_count read exp %0d got %h", top_count_shadow, prdata));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // a set of n scores; score style: 0 full range, 1 narrow pool with many ties, 2 extremes
    task automatic send_set(input int n, input int style);
        logic [SCORE_W-1:0] score;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: score = $urandom;
                1: score = SCORE_W'($signed($urandom_range(0, 4)) - 2);
                default: begin
                    case ($urandom_range(0, 3))
                        0: score = 32'h8000_0000;
                        1: score = 32'h7FFF_FFFF;
                        2: score = 32'hFFFF_FFFF;
                        default: score = $urandom;
                    endcase
                end
            endcase
            send_score(score, i == n - 1);
        end
    endtask

    // reset value of top_count gives the single best index
    task automatic test_reset_top_count();
        send_score(32'd300, 1'b0);
        send_score(32'd1200, 1'b0);
        send_score(-32'sd50, 1'b0);
        send_score(32'd1199, 1'b1);
        stop_stream();
        wait_drained();
    endtask

    // field extremes and a top_count above the set size
    task automatic test_score_extremes();
        write_reg(APB_ADDR_W'(REG_TOP_COUNT * 4), 32'd64);
        send_score(32'h8000_0000, 1'b0);
        send_score(32'h7FFF_FFFF, 1'b0);
        send_score(32'h0000_0000, 1'b0);
        send_score(32'hFFFF_FFFF, 1'b0);
        send_score(32'h0000_0001, 1'b0);
        send_score(32'h5555_5555, 1'b0);
        send_score(32'hAAAA_AAAA, 1'b0);
        send_score(32'h7FFF_FFFF, 1'b1);
        stop_stream();
        wait_drained();
    endtask

    // equal scores keep load order
    task automatic test_equal_scores();
        write_reg(APB_ADDR_W'(REG_TOP_COUNT * 4), 32'd4);
        send_score(32'd5, 1'b0);
        send_score(32'd5, 1'b0);
        send_score(-32'sd3, 1'b0);
        send_score(32'd5, 1'b0);
        send_score(-32'sd3, 1'b0);
        send_score(32'd5, 1'b1);
        // a set of one record
        send_score(32'd77, 1'b1);
        stop_stream();
        wait_drained();
    endtask

    // zero top_count emits nothing; an unmapped write leaves top_count alone
    task automatic test_zero_and_unmapped();
        write_reg(APB_ADDR_W'(REG_TOP_COUNT * 4), 32'h0000_0080);
        send_score(32'd10, 1'b0);
        send_score(32'd20, 1'b0);
        send_score(32'd30, 1'b1);
        stop_stream();
        wait_drained();
        write_reg(APB_ADDR_W'((REG_TOP_COUNT + 1) * 4), 32'hFFFF_FFFF);
        write_reg(APB_ADDR_W'(REG_TOP_COUNT * 4), 32'd2);
        write_reg(APB_ADDR_W'((REG_TOP_COUNT + 1) * 4), 32'd9);
        send_score(32'd1, 1'b0);
        send_score(32'd3, 1'b1);
        stop_stream();
        wait_drained();
    endtask

    // a full store, then a set whose extra beats, the last one included, are dropped
    task automatic test_store_full();
        write_reg(APB_ADDR_W'(REG_TOP_COUNT * 4), 32'd127);
        send_set(MAX_RECORDS, 0);
        stop_stream();
        wait_drained();
        write_reg(APB_ADDR_W'(REG_TOP_COUNT * 4), 32'd64);
        send_set(MAX_RECORDS + 6, 1);
        stop_stream();
        wait_drained();
    endtask

    // random sets of mostly small size under one top_count and one idle pattern
    task automatic test_random_sets(input int items, input int top, input int idle_pct,
                                    input int stall_pct);
        int sent;
        int n;
        int r;
        sent = 0;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        write_reg(APB_ADDR_W'(REG_TOP_COUNT * 4), APB_DATA_W'(top));
        while (sent < items) begin
            r = $urandom_range(99);
            if (r < 75)
                n = $urandom_range(1, 8);
            else if (r < 95)
                n = $urandom_range(9, 24);
            else
                n = $urandom_range(40, MAX_RECORDS);
            send_set(n, $urandom_range(0, 2));
            sent += n;
        end
        stop_stream();
        wait_drained();
    endtask

    initial begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        top_count_shadow = TOP_COUNT_RST;
        last_set_size   = 0;
        mismatches      = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_top_count();
        test_score_extremes();
        test_equal_scores();
        test_zero_and_unmapped();
        test_store_full();
        test_random_sets(10, 64, 0, 0);
        test_random_sets(10, $urandom_range(2, 63), 51, 0);
        test_random_sets(10, 127, 0, 51);
        test_random_sets(10, 1, 18, 18);
        test_random_sets(10, $urandom_range(1, 64), 0, 0);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
